// File: hdl/hda_pkg.sv
// Package for the haversine distance alert block.
// Types, fixed-point constants and the arctangent table used by the CORDIC, square root and top files.
// No dependencies.
package hda_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int W_STEP       = $clog2(CORDIC_STEPS);
    localparam int W_XY         = 34;
    localparam int W_Z          = 35;
    localparam int W_MUL        = 35;
    localparam int W_PROD       = 2 * W_MUL;
    // quotient estimate is low by at most four
    localparam int DIV_STEPS    = 4;
    localparam int W_DIV_CNT    = $clog2(DIV_STEPS);
    localparam int W_SQ_IN      = 61;
    localparam int W_SQ_OUT     = 31;

    localparam logic [63:0] HALF_TURN_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] UNITS_HALF_TURN_64 = 64'd1800000000;
    localparam logic [30:0] UNITS_HALF_TURN    = 31'd1800000000;
    localparam logic [30:0] CONV_QUOT = 31'(HALF_TURN_Q60 / UNITS_HALF_TURN_64);
    localparam logic [30:0] CONV_REM  = 31'(HALF_TURN_Q60 % UNITS_HALF_TURN_64);
    // floor(2^62 / units per half turn)
    localparam logic [31:0] CONV_RECIP = 32'((64'd1 << 62) / UNITS_HALF_TURN_64);

    localparam logic signed [W_Z-1:0]  PI_Q30       = W_Z'(HALF_TURN_Q60 >> 30);
    localparam logic signed [W_Z-1:0]  HALF_PI_Q30  = W_Z'(HALF_TURN_Q60 >> 31);
    localparam logic signed [W_XY-1:0] GAIN_INV_Q30 = W_XY'(652032874);
    localparam logic [30:0]            ONE_Q30      = 31'h4000_0000;
    localparam logic [29:0]            RADIUS_CM    = 30'd637279756;
    localparam logic [30:0]            DIST_MAX     = 31'd2002100000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CV_MUL_REM,
        ST_CV_DIV_INIT,
        ST_CV_QMUL,
        ST_CV_RSUB,
        ST_CV_DIV,
        ST_CV_ANGLE,
        ST_ROT_WAIT,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_T,
        ST_MUL_BT,
        ST_HAV,
        ST_SQRT_S,
        ST_SQRT_C,
        ST_ARC,
        ST_DIST,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_0,
        PH_1,
        PH_2,
        PH_3
    } t_phase;

    typedef struct packed {
        logic start;
        logic vector;
    } t_cordic_cmd;

    typedef logic [CORDIC_STEPS-1:0][W_Z-1:0] t_atan_tab;

    // atan(2^-i) in Q30, series evaluated in Q60 with truncated terms
    function automatic t_atan_tab f_atan_tab();
        t_atan_tab   tab;
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        logic        add_term;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                tab[i] = W_Z'(HALF_TURN_Q60 >> 32);
            end else begin
                acc      = '0;
                add_term = 1'b1;
                for (int n = 1; n < 64; n += 2) begin
                    sh = i * n;
                    if (sh < 60) begin
                        term     = ((64'd1 << 60) >> sh) / 64'(n);
                        acc      = add_term ? acc + term : acc - term;
                        add_term = ~add_term;
                    end
                end
                tab[i] = W_Z'(acc >> 30);
            end
        end
        return tab;
    endfunction

endpackage

// File: hdl/hda_if.sv
// Valid/ready channel interfaces for the haversine distance alert block.
// Input item: two remote and two local position readings. Output item: distance and alert.
// No dependencies.
interface hda_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] remote_lon_a;
    logic signed [31:0] remote_lon_b;
    logic signed [30:0] remote_lat_a;
    logic signed [30:0] remote_lat_b;
    logic signed [31:0] local_lon_a;
    logic signed [31:0] local_lon_b;
    logic signed [30:0] local_lat_a;
    logic signed [30:0] local_lat_b;

    modport source (
        output valid, remote_lon_a, remote_lon_b, remote_lat_a, remote_lat_b,
               local_lon_a, local_lon_b, local_lat_a, local_lat_b,
        input  ready
    );
    modport sink (
        input  valid, remote_lon_a, remote_lon_b, remote_lat_a, remote_lat_b,
               local_lon_a, local_lon_b, local_lat_a, local_lat_b,
        output ready
    );
endinterface

interface hda_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] distance_cm;
    logic        play_alert;

    modport source (output valid, distance_cm, play_alert, input ready);
    modport sink (input valid, distance_cm, play_alert, output ready);
endinterface

// File: hdl/hda_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Rotation mode folds the angle into +-pi/2 and negates the result when folded.
// Depends on hda_pkg.
module hda_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hda_pkg::t_cordic_cmd             i_cmd,
    input  logic signed [hda_pkg::W_XY-1:0]  i_x,
    input  logic signed [hda_pkg::W_XY-1:0]  i_y,
    input  logic signed [hda_pkg::W_Z-1:0]   i_z,
    output logic                             o_done,
    output logic signed [hda_pkg::W_XY-1:0]  o_x,
    output logic signed [hda_pkg::W_XY-1:0]  o_y,
    output logic signed [hda_pkg::W_Z-1:0]   o_z
);
    import hda_pkg::*;

    localparam t_atan_tab ATAN_TAB = f_atan_tab();

    logic                    r_busy;
    logic                    r_done;
    logic [W_STEP-1:0]       r_i;
    logic                    r_vec;
    logic                    r_neg;
    logic signed [W_XY-1:0]  r_x;
    logic signed [W_XY-1:0]  r_y;
    logic signed [W_Z-1:0]   r_z;

    logic                    sigma;
    logic signed [W_XY-1:0]  sx;
    logic signed [W_XY-1:0]  sy;
    logic signed [W_Z-1:0]   ang;
    logic signed [W_Z-1:0]   z_fold;
    logic                    neg_fold;

    always_comb begin
        sigma = r_vec ? r_y[W_XY-1] : ~r_z[W_Z-1];
        sx    = r_x >>> r_i;
        sy    = r_y >>> r_i;
        ang   = signed'(ATAN_TAB[r_i]);
    end

    always_comb begin
        z_fold   = i_z;
        neg_fold = 1'b0;
        if (i_z > HALF_PI_Q30) begin
            z_fold   = i_z - PI_Q30;
            neg_fold = 1'b1;
        end else if (i_z < -HALF_PI_Q30) begin
            z_fold   = i_z + PI_Q30;
            neg_fold = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_vec  <= i_cmd.vector;
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_cmd.vector ? i_z : z_fold;
                r_neg  <= i_cmd.vector ? 1'b0 : neg_fold;
            end else if (r_busy) begin
                r_x <= sigma ? r_x - sy : r_x + sy;
                r_y <= sigma ? r_y + sx : r_y - sx;
                r_z <= sigma ? r_z - ang : r_z + ang;
                if (r_i == W_STEP'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_z    = r_z;

endmodule

// File: hdl/hda_isqrt.sv
// Bit-serial integer square root, one result bit per cycle, floor result.
// Takes a 61-bit radicand and returns a 31-bit root.
// Depends on hda_pkg.
module hda_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hda_pkg::W_SQ_IN-1:0]   i_n,
    output logic                          o_done,
    output logic [hda_pkg::W_SQ_OUT-1:0]  o_root
);
    import hda_pkg::*;

    localparam int W_ACC = W_SQ_IN + 1;

    logic             r_busy;
    logic             r_done;
    logic [W_ACC-1:0] r_n;
    logic [W_ACC-1:0] r_res;
    logic [W_ACC-1:0] r_bit;

    logic [W_ACC-1:0] trial;
    logic             ge;

    assign trial = r_res + r_bit;
    assign ge    = r_n >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= {1'b0, i_n};
                r_res  <= '0;
                r_bit  <= W_ACC'(1) << (W_SQ_IN - 1);
            end else if (r_busy) begin
                if (ge) begin
                    r_n   <= r_n - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[W_SQ_OUT-1:0];

endmodule

// File: hdl/haversine_distance_alert_top.sv
// Haversine distance alert: averages position readings, computes great-circle distance in cm.
// Each item takes four CORDIC rotations, four reciprocal divides, two square roots and
// one vectoring pass, run one after another.
// One item at a time: ready only when idle, after the last result is in the output register.
// Synchronous active-low reset clears the sequencer, the output valid, the phase and both slots.
// Depends on hda_pkg, hda_if, hda_cordic, hda_isqrt.
module haversine_distance_alert_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hda_in_if.sink     i_in,
    hda_out_if.source  o_out
);
    import hda_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase;

    logic                    in_acc;
    logic                    in_ready;
    t_cordic_cmd             cmd;
    logic                    sq_start;
    logic                    mul_en;

    logic signed [30:0]      r_lat1, r_lat2;
    logic signed [31:0]      r_dlat;
    logic signed [32:0]      r_dlon;
    logic [1:0]              r_k;
    logic [W_DIV_CNT-1:0]    r_cnt;
    logic [34:0]             r_num;
    logic [34:0]             r_rem;
    logic [32:0]             r_dvd;
    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_XY-1:0]  r_c1, r_c2, r_sdl, r_sdo;
    logic signed [W_MUL-1:0] r_a, r_b;
    logic [30:0]             r_h;
    logic [W_SQ_OUT-1:0]     r_rs;
    logic [30:0]             r_d;
    logic [30:0]             r_slot1, r_slot2;
    logic                    r_out_valid;
    logic [30:0]             r_out_dist;
    logic                    r_out_alert;

    logic [32:0]             s_rlon, s_llon;
    logic [31:0]             s_rlat, s_llat;
    logic signed [31:0]      rlon, llon;
    logic signed [30:0]      rlat, llat;
    logic signed [32:0]      unit;
    logic [32:0]             mag;
    logic [63:0]             tot;
    logic [33:0]             ang_mag;
    logic signed [W_Z-1:0]   angle;
    logic                    ge;
    logic signed [W_MUL-1:0] mul_a, mul_b;
    logic signed [W_MUL:0]   hsum;
    logic [30:0]             h_c;
    logic signed [W_Z-1:0]   arc;
    logic [34:0]             dist_raw;
    logic                    alert;
    logic                    out_load;

    logic                    cor_done;
    logic signed [W_XY-1:0]  cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [W_Z-1:0]   cor_z_in, cor_z;
    logic                    sq_done;
    logic [W_SQ_IN-1:0]      sq_n;
    logic [W_SQ_OUT-1:0]     sq_root;

    // averaging, floor
    always_comb begin
        s_rlon = {i_in.remote_lon_a[31], i_in.remote_lon_a}
               + {i_in.remote_lon_b[31], i_in.remote_lon_b};
        s_llon = {i_in.local_lon_a[31], i_in.local_lon_a}
               + {i_in.local_lon_b[31], i_in.local_lon_b};
        s_rlat = {i_in.remote_lat_a[30], i_in.remote_lat_a}
               + {i_in.remote_lat_b[30], i_in.remote_lat_b};
        s_llat = {i_in.local_lat_a[30], i_in.local_lat_a}
               + {i_in.local_lat_b[30], i_in.local_lat_b};
        rlon   = signed'(s_rlon[32:1]);
        llon   = signed'(s_llon[32:1]);
        rlat   = signed'(s_rlat[31:1]);
        llat   = signed'(s_llat[31:1]);
    end

    // angle conversion operands
    always_comb begin
        case (r_k)
            2'd0:    unit = {{2{r_lat1[30]}}, r_lat1};
            2'd1:    unit = {{2{r_lat2[30]}}, r_lat2};
            2'd2:    unit = {r_dlat[31], r_dlat};
            default: unit = r_dlon;
        endcase
        mag     = unit[32] ? 33'(-unit) : unit;
        tot     = r_prod[63:0] + {31'b0, r_dvd};
        ang_mag = r_k[1] ? {1'b0, tot[63:31]} : tot[63:30];
        angle   = unit[32] ? -signed'({1'b0, ang_mag}) : signed'({1'b0, ang_mag});
        ge      = r_rem >= {4'b0, UNITS_HALF_TURN};
    end

    // haversine sum, clamp, arc and distance
    always_comb begin
        hsum = {r_a[W_MUL-1], r_a} + {r_prod[64], r_prod[64:30]};
        if (hsum[W_MUL]) begin
            h_c = '0;
        end else if (hsum > signed'({5'b0, ONE_Q30})) begin
            h_c = ONE_Q30;
        end else begin
            h_c = hsum[30:0];
        end
        arc      = cor_z[W_Z-1] ? '0 : cor_z;
        dist_raw = r_prod[63:29];
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_CV_MUL_REM: begin
                mul_a = signed'({2'b0, mag});
                mul_b = signed'({4'b0, CONV_REM});
            end
            ST_CV_DIV_INIT: begin
                mul_a = signed'({3'b0, r_prod[62:31]});
                mul_b = signed'({3'b0, CONV_RECIP});
            end
            ST_CV_QMUL: begin
                mul_a = signed'({2'b0, r_prod[63:31]});
                mul_b = signed'({4'b0, UNITS_HALF_TURN});
            end
            ST_CV_RSUB: begin
                mul_a = signed'({2'b0, mag});
                mul_b = signed'({4'b0, CONV_QUOT});
            end
            ST_MUL_A: begin
                mul_a = {r_sdl[W_XY-1], r_sdl};
                mul_b = {r_sdl[W_XY-1], r_sdl};
            end
            ST_MUL_B: begin
                mul_a = {r_c1[W_XY-1], r_c1};
                mul_b = {r_c2[W_XY-1], r_c2};
            end
            ST_MUL_T: begin
                mul_a = {r_sdo[W_XY-1], r_sdo};
                mul_b = {r_sdo[W_XY-1], r_sdo};
            end
            ST_MUL_BT: begin
                mul_a = r_b;
                mul_b = r_prod[64:30];
            end
            ST_ARC: begin
                mul_a = arc;
                mul_b = signed'({5'b0, RADIUS_CM});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        sq_start = 1'b0;
        mul_en   = 1'b0;
        in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) n_state = ST_CV_MUL_REM;
            end
            ST_CV_MUL_REM: begin
                mul_en  = 1'b1;
                n_state = ST_CV_DIV_INIT;
            end
            ST_CV_DIV_INIT: begin
                mul_en  = 1'b1;
                n_state = ST_CV_QMUL;
            end
            ST_CV_QMUL: begin
                mul_en  = 1'b1;
                n_state = ST_CV_RSUB;
            end
            ST_CV_RSUB: begin
                mul_en  = 1'b1;
                n_state = ST_CV_DIV;
            end
            ST_CV_DIV: begin
                if (r_cnt == W_DIV_CNT'(DIV_STEPS - 1)) n_state = ST_CV_ANGLE;
            end
            ST_CV_ANGLE: begin
                cmd.start = 1'b1;
                n_state   = ST_ROT_WAIT;
            end
            ST_ROT_WAIT: begin
                if (cor_done) n_state = (r_k == 2'd3) ? ST_MUL_A : ST_CV_MUL_REM;
            end
            ST_MUL_A: begin
                mul_en  = 1'b1;
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                mul_en  = 1'b1;
                n_state = ST_MUL_T;
            end
            ST_MUL_T: begin
                mul_en  = 1'b1;
                n_state = ST_MUL_BT;
            end
            ST_MUL_BT: begin
                mul_en  = 1'b1;
                n_state = ST_HAV;
            end
            ST_HAV: begin
                sq_start = 1'b1;
                n_state  = ST_SQRT_S;
            end
            ST_SQRT_S: begin
                if (sq_done) begin
                    sq_start = 1'b1;
                    n_state  = ST_SQRT_C;
                end
            end
            ST_SQRT_C: begin
                if (sq_done) begin
                    cmd.start  = 1'b1;
                    cmd.vector = 1'b1;
                    n_state    = ST_ARC;
                end
            end
            ST_ARC: begin
                if (cor_done) begin
                    mul_en  = 1'b1;
                    n_state = ST_DIST;
                end
            end
            ST_DIST: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign in_acc   = i_in.valid && in_ready;
    assign cor_x_in = cmd.vector ? signed'({3'b0, sq_root}) : GAIN_INV_Q30;
    assign cor_y_in = cmd.vector ? signed'({3'b0, r_rs}) : '0;
    assign cor_z_in = cmd.vector ? '0 : angle;
    assign sq_n     = (r_state == ST_HAV) ? {h_c, 30'b0} : {ONE_Q30 - r_h, 30'b0};

    hda_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (cor_x_in),
        .i_y     (cor_y_in),
        .i_z     (cor_z_in),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_z     (cor_z)
    );

    hda_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_n),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lat1 <= rlat;
            r_lat2 <= llat;
            r_dlat <= {llat[30], llat} - {rlat[30], rlat};
            r_dlon <= {llon[31], llon} - {rlon[31], rlon};
            r_k    <= '0;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (r_state)
            ST_CV_DIV_INIT: begin
                r_num <= r_prod[34:0];
            end
            ST_CV_QMUL: begin
                r_dvd <= r_prod[63:31];
            end
            ST_CV_RSUB: begin
                r_rem <= r_num - r_prod[34:0];
                r_cnt <= '0;
            end
            ST_CV_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - {4'b0, UNITS_HALF_TURN};
                    r_dvd <= r_dvd + 33'd1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            ST_ROT_WAIT: begin
                if (cor_done) begin
                    case (r_k)
                        2'd0:    r_c1  <= cor_x;
                        2'd1:    r_c2  <= cor_x;
                        2'd2:    r_sdl <= cor_y;
                        default: r_sdo <= cor_y;
                    endcase
                    r_k <= r_k + 1'b1;
                end
            end
            ST_MUL_B: r_a <= r_prod[64:30];
            ST_MUL_T: r_b <= r_prod[64:30];
            ST_HAV:   r_h <= h_c;
            ST_SQRT_S: begin
                if (sq_done) r_rs <= sq_root;
            end
            ST_DIST: begin
                r_d <= (dist_raw > {4'b0, DIST_MAX}) ? DIST_MAX : dist_raw[30:0];
            end
            default: begin
            end
        endcase
    end

    // alert rule and output register
    always_comb begin
        case (r_phase)
            PH_1:    alert = 1'b1;
            PH_3:    alert = r_d <= r_slot2;
            default: alert = r_slot1 <= r_d;
        endcase
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= PH_0;
            r_slot1     <= '0;
            r_slot2     <= '0;
        end else begin
            if (o_out.ready) r_out_valid <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_dist  <= r_d;
                r_out_alert <= alert;
                if (r_phase == PH_0 || r_phase == PH_2) begin
                    r_slot2 <= r_d;
                end else begin
                    r_slot1 <= r_d;
                end
                case (r_phase)
                    PH_0:    r_phase <= PH_1;
                    PH_1:    r_phase <= PH_2;
                    PH_2:    r_phase <= PH_3;
                    default: r_phase <= PH_2;
                endcase
            end
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.distance_cm = r_out_dist;
    assign o_out.play_alert  = r_out_alert;

`ifndef SYNTHESIS
    a_phase_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_3) |=> (r_phase == PH_3 || r_phase == PH_2))
        else $error("phase left the 2/3 cycle");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.distance_cm <= DIST_MAX))
        else $error("distance above saturation limit");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> (r_state == ST_ROT_WAIT || r_state == ST_ARC))
        else $error("cordic finished outside a wait state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not presented after load");
`endif

endmodule
